/* hdl/ptss_pkg.sv */
package ptss_pkg;

   localparam int NUM_SLOTS = 8;
   localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int MAX_RES   = 8;
   localparam int CNT_W     = $clog2(MAX_RES + 1);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_RES - 1);

   localparam logic [2:0] OP_ADD      = 3'd0;
   localparam logic [2:0] OP_DELETE   = 3'd1;
   localparam logic [2:0] OP_QUERY    = 3'd2;
   localparam logic [2:0] OP_TICK     = 3'd3;
   localparam logic [2:0] OP_DISPATCH = 3'd4;

   localparam logic [1:0] STAT_RUNNABLE = 2'd0;
   localparam logic [1:0] STAT_RUNNING  = 2'd1;
   localparam logic [1:0] STAT_STOPPED  = 2'd2;
   localparam logic [1:0] STAT_ERROR    = 2'd3;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  task_id;
      logic [15:0] period;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic       added;
      logic       fired;
      logic [7:0] fired_id;
      logic [2:0] fired_slot;
      logic       last;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0]  id;
      logic [15:0] period;
      logic [15:0] countdown;
      logic [1:0]  state;
   } slot_type;

   localparam slot_type SLOT_RESET = '{id: 8'd0, period: 16'd0, countdown: 16'd0,
                                       state: STAT_STOPPED};

endpackage

/* hdl/ptss_ram.sv */
module ptss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/periodic_task_slot_scheduler_core.sv */
// A transaction sweeps the slot table from slot 0 until its final result is presented:
//   add, delete and query stop at the first hit, tick visits all slots, and dispatch
//   visits all slots unless it reaches MAX_RES fires. One transaction at a time: req_stall
//   holds off a new one until the final result is loaded; the slot table has a single read
//   port and the sweep reads one slot per cycle unless a fire result is stalled.
// Dispatch holds each fire result back until the next fire or the final result; a stalled
//   result holds the sweep. Reset (synchronous) clears the per-slot valid bits; no clearing pass.
module periodic_task_slot_scheduler_core
   import ptss_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,   // waiting for a transaction
      S_RD   = 4'b0010,   // first slot read issued
      S_EV   = 4'b0100,   // slot data present: evaluate, write back, read next
      S_FIN  = 4'b1000    // final result of the transaction
   } state_type;

   state_type       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] fire_cnt_ff, fire_cnt_in;

   // captured transaction
   logic [2:0]  op_ff;
   logic [7:0]  id_ff;
   logic [15:0] per_ff;

   logic [1:0]  status_ff, status_in;
   logic        added_ff, added_in;

   // a fire result is held back until the next fire or the final result so that its last flag is known
   logic             pend_vld_ff, pend_vld_in;
   logic [7:0]       pend_id_ff, pend_id_in;
   logic [IDX_W-1:0] pend_slot_ff, pend_slot_in;

   // entry written since reset; an unwritten entry reads as its reset value
   logic [NUM_SLOTS-1:0] valid_ff, valid_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic             wr_en, rd_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   slot_type         wr_data, rd_data, cur;
   logic             push, out_free, accept, advance;
   rsp_payload_type  push_data;

   ptss_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cur       = valid_ff[idx_ff] ? rd_data : SLOT_RESET;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      fire_cnt_in  = fire_cnt_ff;
      status_in    = status_ff;
      added_in     = added_ff;
      pend_vld_in  = pend_vld_ff;
      pend_id_in   = pend_id_ff;
      pend_slot_in = pend_slot_ff;
      valid_in     = valid_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = cur;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      push         = 1'b0;
      push_data    = '0;
      advance      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in      = '0;
               fire_cnt_in = '0;
               status_in   = STAT_ERROR;
               added_in    = 1'b0;
               pend_vld_in = 1'b0;
               // unknown codes are dropped without a result
               if (req_payload.operation inside {[OP_ADD:OP_DISPATCH]}) begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            rd_addr  = idx_ff;
            state_in = S_EV;
         end
         S_EV: begin
            case (op_ff)
               OP_ADD: begin
                  if (cur.state == STAT_STOPPED) begin
                     wr_en    = 1'b1;
                     wr_data  = '{id: id_ff, period: per_ff, countdown: per_ff,
                                  state: STAT_RUNNABLE};
                     added_in = 1'b1;
                     state_in = S_FIN;
                  end else begin
                     advance = 1'b1;
                  end
               end
               OP_DELETE: begin
                  if (cur.id == id_ff) begin
                     wr_en         = 1'b1;
                     wr_data.state = STAT_STOPPED;
                     state_in      = S_FIN;
                  end else begin
                     advance = 1'b1;
                  end
               end
               OP_QUERY: begin
                  if (cur.id == id_ff) begin
                     status_in = cur.state;
                     state_in  = S_FIN;
                  end else begin
                     advance = 1'b1;
                  end
               end
               OP_TICK: begin
                  // countdown saturates at zero
                  if (cur.state == STAT_RUNNABLE && cur.countdown != 16'd0) begin
                     wr_en             = 1'b1;
                     wr_data.countdown = cur.countdown - 16'd1;
                  end
                  advance = 1'b1;
               end
               OP_DISPATCH: begin
                  if (cur.state == STAT_RUNNABLE && cur.countdown == 16'd0) begin
                     // held fire must leave first; wait while the output register is full and stalled
                     if (!pend_vld_ff || out_free) begin
                        wr_en             = 1'b1;
                        wr_data.countdown = cur.period;
                        if (pend_vld_ff) begin
                           push      = 1'b1;
                           push_data = '{status: 2'd0, added: 1'b0, fired: 1'b1,
                                         fired_id: pend_id_ff,
                                         fired_slot: 3'(pend_slot_ff), last: 1'b0};
                        end
                        pend_vld_in  = 1'b1;
                        pend_id_in   = cur.id;
                        pend_slot_in = idx_ff;
                        fire_cnt_in  = fire_cnt_ff + 1'b1;
                        if (fire_cnt_ff == LAST_CNT) begin
                           state_in = S_FIN;   // cap reached, rest stay due
                        end else begin
                           advance = 1'b1;
                        end
                     end
                  end else begin
                     advance = 1'b1;
                  end
               end
               default: state_in = S_FIN;
            endcase

            if (wr_en) begin
               valid_in[idx_ff] = 1'b1;
            end

            if (advance) begin
               if (idx_ff == LAST_IDX) begin
                  state_in = S_FIN;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  rd_en    = 1'b1;
                  rd_addr  = idx_ff + 1'b1;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               push = 1'b1;
               if (op_ff == OP_DISPATCH) begin
                  if (pend_vld_ff) begin
                     push_data = '{status: 2'd0, added: 1'b0, fired: 1'b1,
                                   fired_id: pend_id_ff,
                                   fired_slot: 3'(pend_slot_ff), last: 1'b1};
                  end else begin
                     push_data.last = 1'b1;
                  end
               end else begin
                  push_data.status = (op_ff == OP_QUERY) ? status_ff : 2'd0;
                  push_data.added  = added_ff;
                  push_data.last   = 1'b1;
               end
               pend_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register: loaded on push, cleared once taken
   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      if (push) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = push_data;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_payload.operation;
         id_ff  <= req_payload.task_id;
         per_ff <= req_payload.period;
      end
      idx_ff         <= idx_in;
      fire_cnt_ff    <= fire_cnt_in;
      status_ff      <= status_in;
      added_ff       <= added_in;
      pend_id_ff     <= pend_id_in;
      pend_slot_ff   <= pend_slot_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // a new result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      push |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

   // write-back and next read never hit the same slot in one cycle
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("slot table read and write collide");

   // fire results carry no query or add answer
   a_fire_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.fired) |-> (rsp_payload.status == 2'd0 && !rsp_payload.added))
      else $error("fire result carries status or added");

   // a transaction finishing in FIN always returns to idle with nothing held back
   a_fin_drains: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && out_free) |=> (state_ff == S_IDLE && !pend_vld_ff))
      else $error("final result did not drain the held fire");

endmodule

/* test/periodic_task_slot_scheduler_core_test.sv */
`timescale 1ns / 100ps

module periodic_task_slot_scheduler_core_test
   import ptss_pkg::*;
();

   // Operation codes the block ignores (no result).
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   localparam int RANDOM_ITEMS  = 120;
   localparam int QUIET_FROM    = 95;    // last stretch runs without idling
   localparam int HOLD_AT_ITEM  = 40;    // where the long receiver hold-off starts
   localparam int LONG_HOLD     = 200;
   localparam int DRAIN_CYCLES  = NUM_SLOTS + 8;
   localparam int LIMIT_NS      = 1_000_000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   // Testbench-side copy of the slot table.
   slot_type        sched_slots [NUM_SLOTS];
   // Results still owed by the block, oldest first.
   rsp_payload_type pending_answers [$];

   // Directed stimulus table.
   req_payload_type dir_req   [$];
   bit              dir_typed [$];
   rsp_payload_type dir_want  [$];

   int  fail_count = 0;
   bit  quiet = 1'b0;             // no idling on either side when set
   bit  want_long_hold = 1'b0;
   bit  long_hold_done = 1'b0;

   periodic_task_slot_scheduler_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #(LIMIT_NS);
      $display("tb: failure");
      $finish;
   end

   // Single-result answer with last set; used for rows whose result is obvious.
   function automatic rsp_payload_type single_answer(input logic [1:0] status,
                                                     input logic added);
      rsp_payload_type r;
      r        = '0;
      r.status = status;
      r.added  = added;
      r.last   = 1'b1;
      return r;
   endfunction

   // Advance the slot table copy by one accepted transaction and queue the
   // results it causes. A typed row supplies its own single result instead.
   task automatic step_slot_table(input req_payload_type p, input bit typed,
                                  input rsp_payload_type want);
      rsp_payload_type r;
      rsp_payload_type answers [$];
      bit              hit;
      int              fired_n;
      r       = '0;
      r.last  = 1'b1;
      hit     = 1'b0;
      fired_n = 0;
      case (p.operation)
         OP_ADD: begin
            // first stopped slot takes the task, countdown starts at period
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!hit && sched_slots[i].state == STAT_STOPPED) begin
                  sched_slots[i].id        = p.task_id;
                  sched_slots[i].period    = p.period;
                  sched_slots[i].countdown = p.period;
                  sched_slots[i].state     = STAT_RUNNABLE;
                  hit = 1'b1;
               end
            end
            r.added = hit;
            answers.push_back(r);
         end
         OP_DELETE: begin
            // id match includes stopped slots
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!hit && sched_slots[i].id == p.task_id) begin
                  sched_slots[i].state = STAT_STOPPED;
                  hit = 1'b1;
               end
            end
            answers.push_back(r);
         end
         OP_QUERY: begin
            r.status = STAT_ERROR;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!hit && sched_slots[i].id == p.task_id) begin
                  r.status = sched_slots[i].state;
                  hit = 1'b1;
               end
            end
            answers.push_back(r);
         end
         OP_TICK: begin
            // countdown saturates at zero
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (sched_slots[i].state == STAT_RUNNABLE && sched_slots[i].countdown != 0)
                  sched_slots[i].countdown = sched_slots[i].countdown - 16'd1;
            end
            answers.push_back(r);
         end
         OP_DISPATCH: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (fired_n < MAX_RES && sched_slots[i].state == STAT_RUNNABLE &&
                   sched_slots[i].countdown == 0) begin
                  sched_slots[i].countdown = sched_slots[i].period;
                  r            = '0;
                  r.fired      = 1'b1;
                  r.fired_id   = sched_slots[i].id;
                  r.fired_slot = 3'(i);
                  answers.push_back(r);
                  fired_n++;
               end
            end
            if (fired_n == 0) begin
               r      = '0;
               r.last = 1'b1;
               answers.push_back(r);
            end else begin
               r      = answers.pop_back();
               r.last = 1'b1;
               answers.push_back(r);
            end
         end
         default: ;   // spare codes: ignored, nothing owed
      endcase
      if (typed)
         pending_answers.push_back(want);
      else
         foreach (answers[k]) pending_answers.push_back(answers[k]);
   endtask

   // Offer one transaction; called at a falling edge, returns at a falling edge.
   // A random idle gap, with noise on the payload, sometimes precedes it unless the run is in its quiet part.
   task automatic drive_item(input req_payload_type p, input bit typed,
                             input rsp_payload_type want);
      logic [31:0] noise;
      int          gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap   = $urandom_range(1, 15);
         noise = $urandom;
         req_valid   <= 1'b0;
         req_payload <= noise[$bits(req_payload_type)-1:0];
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      step_slot_table(p, typed, want);
      @(negedge clock);
   endtask

   task automatic put_row(input logic [2:0] op, input logic [7:0] id,
                          input logic [15:0] per, input bit typed,
                          input rsp_payload_type want);
      req_payload_type p;
      p.operation = op;
      p.task_id   = id;
      p.period    = per;
      dir_req.push_back(p);
      dir_typed.push_back(typed);
      dir_want.push_back(want);
   endtask

   // Receiver: random stall bursts, one long hold-off once asked for, none when quiet.
   initial begin
      int burst;
      forever begin
         @(negedge clock);
         if (want_long_hold && !long_hold_done) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(negedge clock);
            long_hold_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 15);
            rsp_stall <= 1'b1;
            repeat (burst - 1) @(negedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Result checker: every accepted result against the oldest owed one.
   always @(posedge clock) begin
      rsp_payload_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected result transaction %h", rsp_payload);
            fail_count++;
         end else begin
            exp_rsp = pending_answers.pop_front();
            if (rsp_payload.status !== exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, rsp_payload.status);
               fail_count++;
            end
            if (rsp_payload.added !== exp_rsp.added) begin
               $error("added: expected %0d, got %0d", exp_rsp.added, rsp_payload.added);
               fail_count++;
            end
            if (rsp_payload.fired !== exp_rsp.fired) begin
               $error("fired: expected %0d, got %0d", exp_rsp.fired, rsp_payload.fired);
               fail_count++;
            end
            if (rsp_payload.fired_id !== exp_rsp.fired_id) begin
               $error("fired_id: expected %0h, got %0h", exp_rsp.fired_id,
                      rsp_payload.fired_id);
               fail_count++;
            end
            if (rsp_payload.fired_slot !== exp_rsp.fired_slot) begin
               $error("fired_slot: expected %0d, got %0d", exp_rsp.fired_slot,
                      rsp_payload.fired_slot);
               fail_count++;
            end
            if (rsp_payload.last !== exp_rsp.last) begin
               $error("last: expected %0d, got %0d", exp_rsp.last, rsp_payload.last);
               fail_count++;
            end
         end
      end
   end

   initial begin
      req_payload_type p;
      int              effective;
      int              pick;
      logic [31:0]     noise;

      foreach (sched_slots[i]) sched_slots[i] = SLOT_RESET;

      // Directed part. Reset ids are zero, so a query for id 0 hits stopped slot 0.
      put_row(OP_QUERY,    8'h00, 16'h0000, 1'b1, single_answer(STAT_STOPPED, 1'b0));
      put_row(OP_QUERY,    8'hFF, 16'hFFFF, 1'b1, single_answer(STAT_ERROR, 1'b0));
      put_row(OP_DISPATCH, 8'h00, 16'h0000, 1'b1, single_answer(STAT_RUNNABLE, 1'b0));
      put_row(OP_TICK,     8'hFF, 16'hFFFF, 1'b1, single_answer(STAT_RUNNABLE, 1'b0));
      put_row(OP_DELETE,   8'h55, 16'h0000, 1'b1, single_answer(STAT_RUNNABLE, 1'b0));
      // period zero: due at every dispatch
      put_row(OP_ADD,      8'h11, 16'h0000, 1'b1, single_answer(STAT_RUNNABLE, 1'b1));
      put_row(OP_ADD,      8'hFF, 16'hFFFF, 1'b1, single_answer(STAT_RUNNABLE, 1'b1));
      put_row(OP_ADD,      8'h00, 16'h0001, 1'b0, '0);
      put_row(OP_QUERY,    8'h11, 16'h0000, 1'b0, '0);
      put_row(OP_DISPATCH, 8'h00, 16'h0000, 1'b0, '0);
      put_row(OP_TICK,     8'h00, 16'h0000, 1'b0, '0);
      put_row(OP_TICK,     8'h00, 16'h0000, 1'b0, '0);   // saturates slot 2 at zero
      put_row(OP_DISPATCH, 8'h00, 16'h0000, 1'b0, '0);
      put_row(OP_ADD,      8'h22, 16'h0002, 1'b0, '0);
      put_row(OP_ADD,      8'h33, 16'h0000, 1'b0, '0);
      put_row(OP_ADD,      8'h44, 16'h0000, 1'b0, '0);
      put_row(OP_ADD,      8'h55, 16'h0001, 1'b0, '0);
      put_row(OP_ADD,      8'h66, 16'h8000, 1'b0, '0);
      // table full: add refused
      put_row(OP_ADD,      8'h77, 16'h0003, 1'b1, single_answer(STAT_RUNNABLE, 1'b0));
      put_row(OP_DISPATCH, 8'h00, 16'h0000, 1'b0, '0);
      put_row(OP_DELETE,   8'hFF, 16'h0000, 1'b0, '0);
      put_row(OP_QUERY,    8'hFF, 16'h0000, 1'b0, '0);
      put_row(OP_SPARE_FIRST, 8'hAA, 16'h5555, 1'b0, '0);
      put_row(OP_SPARE_LAST,  8'h55, 16'hAAAA, 1'b0, '0);
      put_row(OP_DISPATCH, 8'h00, 16'h0000, 1'b0, '0);

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_req[k]) drive_item(dir_req[k], dir_typed[k], dir_want[k]);

      // Random part: mostly table traffic over a small id pool so that deletes
      // and queries hit, some full-range ids and periods, some spare codes.
      effective = 0;
      while (effective < RANDOM_ITEMS) begin
         if (effective == HOLD_AT_ITEM) want_long_hold = 1'b1;
         quiet = (effective >= QUIET_FROM);
         noise = $urandom;
         p.task_id = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 5));
         pick = $urandom_range(0, 9);
         if (pick < 6)
            p.period = 16'($urandom_range(0, 3));
         else if (pick < 9)
            p.period = 16'($urandom_range(0, 40));
         else
            p.period = noise[15:0];
         pick = $urandom_range(0, 99);
         if (pick < 18)
            p.operation = OP_ADD;
         else if (pick < 33)
            p.operation = OP_DELETE;
         else if (pick < 45)
            p.operation = OP_QUERY;
         else if (pick < 70)
            p.operation = OP_TICK;
         else if (pick < 92)
            p.operation = OP_DISPATCH;
         else
            p.operation = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
         if (p.operation == OP_TICK || p.operation == OP_DISPATCH) begin
            // unused fields carry noise
            p.task_id = noise[23:16];
            p.period  = noise[15:0] ^ 16'($urandom);
         end
         drive_item(p, 1'b0, '0);
         if (p.operation <= OP_DISPATCH) effective++;
      end
      req_valid <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
